// ===== hw/rtl/lts_pkg.sv =====
// Shared types and constants of the lightmap texel shader.
package lts_pkg;

  localparam int unsigned SHADE_TABLE_DEPTH = 16384;
  localparam int unsigned BLOCK_SIDE_LOG2   = 4;

  localparam int unsigned LIGHT_W  = 16;
  localparam int unsigned CORNER_W = 14;
  localparam int unsigned INDEX_W  = 14;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned MIP_W    = 2;
  // Width of a colormap address sum, wide enough to compare against any depth below 2**17.
  localparam int unsigned ADDR_SUM_W = 17;
  // Width of a light difference before the arithmetic shift.
  localparam int unsigned DIFF_W = 17;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_BLOCK = 2'd1,
    MODE_TEXEL = 2'd2
  } mode_e;

  typedef struct packed {
    logic [1:0]          mode;
    logic [INDEX_W-1:0]  table_index;
    logic [BYTE_W-1:0]   table_value;
    logic [CORNER_W-1:0] top_left;
    logic [CORNER_W-1:0] top_right;
    logic [CORNER_W-1:0] bottom_left;
    logic [CORNER_W-1:0] bottom_right;
    logic [BYTE_W-1:0]   texel;
  } in_beat_t;

  typedef struct packed {
    logic [BYTE_W-1:0] pixel;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic              last;
  } out_beat_t;

endpackage

// ===== hw/rtl/lts_ram.sv =====
// Generic single-port RAM with a registered read port.
module lts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/lightmap_texel_shader.sv =====
// Top level of the lightmap texel shader: bilinear light stepping and colormap lookup.
//
// The shader lights the texels of one light block, 1 << (BLOCK_SIDE_LOG2 - mip) texels
// on a side. A block-start beat carries the four corner lights in 8.8 fixed point; the
// block keeps the left and right edge lights, their vertical steps, and a row light that
// advances by a horizontal step for each texel. Texel beats arrive in row-major order, and
// each one looks up the colormap at the light's integer part (upper byte) joined with the
// texel's palette index, returning the lit byte with its column, row and a last flag on
// the final texel of the block. Load beats fill the colormap one entry per beat; it holds
// no defined contents after reset and must be loaded before it is read. The shader takes
// one beat of any kind every cycle while in_stall_o is low; the colormap is a
// single-port memory that serves either one load or one lookup per cycle, which is what
// sets that rate. The memory reads at the edge that accepts a texel beat, and the output
// register loads the read data when stage one moves forward. Block-start and load beats
// produce no result. The mip level may only be written while no texel result is
// outstanding.
module lightmap_texel_shader #(
  parameter int unsigned SHADE_TABLE_DEPTH = lts_pkg::SHADE_TABLE_DEPTH,
  parameter int unsigned BLOCK_SIDE_LOG2   = lts_pkg::BLOCK_SIDE_LOG2
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Input channel.
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  lts_pkg::in_beat_t           in_data_i,
  // Output channel.
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output lts_pkg::out_beat_t          out_data_o,
  // Mip level register.
  input  logic                        cfg_we_i,
  input  logic [lts_pkg::MIP_W-1:0]   cfg_wdata_i
);

  // Memory address, counter, shift amount, light, difference and address sum widths.
  localparam int unsigned AW = (SHADE_TABLE_DEPTH > 1) ? $clog2(SHADE_TABLE_DEPTH) : 1;
  localparam int unsigned CW = BLOCK_SIDE_LOG2;
  localparam int unsigned SW = $clog2(BLOCK_SIDE_LOG2 + 1);
  localparam int unsigned LW = lts_pkg::LIGHT_W;
  localparam int unsigned DW = lts_pkg::DIFF_W;
  localparam int unsigned XW = lts_pkg::ADDR_SUM_W;

  // Arithmetic shift of a light difference, truncated to the light width.
  function automatic logic [LW-1:0] step_of(input logic [DW-1:0] d, input logic [SW-1:0] s);
    logic signed [DW-1:0] r;
    r = $signed(d) >>> s;
    return r[LW-1:0];
  endfunction

  // Mip level register.
  logic [lts_pkg::MIP_W-1:0] mip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mip_q <= '0;
    end else if (cfg_we_i) begin
      mip_q <= cfg_wdata_i;
    end
  end

  // The shift amount saturates at zero when the mip level exceeds the side log, which
  // makes the block a single texel.
  logic [SW:0]   side_log;
  logic [SW:0]   mip_ext;
  logic [SW-1:0] shamt;
  logic [CW:0]   side;
  logic [CW:0]   side_m1;

  assign side_log = (SW+1)'(BLOCK_SIDE_LOG2);
  assign mip_ext  = (SW+1)'(mip_q);
  assign shamt    = (mip_ext >= side_log) ? '0 : SW'(side_log - mip_ext);
  assign side     = (CW+1)'(1) << shamt;
  assign side_m1  = side - (CW+1)'(1);

  // Handshake and pipeline control. Stage one holds the memory read data, and the output
  // register sits behind it; stage one moves forward whenever the output register is empty
  // or being drained.
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  logic s1_adv;
  logic in_acc;

  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  logic is_load, is_block, is_texel;

  always_comb begin
    is_load  = 1'b0;
    is_block = 1'b0;
    is_texel = 1'b0;
    unique case (in_data_i.mode)
      lts_pkg::MODE_LOAD:  is_load  = 1'b1;
      lts_pkg::MODE_BLOCK: is_block = 1'b1;
      lts_pkg::MODE_TEXEL: is_texel = 1'b1;
      default: ;
    endcase
  end

  // Light state.
  logic [LW-1:0] left_light_q, left_light_d;
  logic [LW-1:0] right_light_q, right_light_d;
  logic [LW-1:0] left_vstep_q, left_vstep_d;
  logic [LW-1:0] right_vstep_q, right_vstep_d;
  logic [LW-1:0] row_light_q, row_light_d;
  logic [LW-1:0] row_step_q, row_step_d;
  logic [CW-1:0] col_count_q, col_count_d;
  logic [CW-1:0] row_count_q, row_count_d;

  // Row advance: the edge lights step down, and the new row's horizontal step comes from
  // the stepped edges taken as signed 16-bit values.
  logic [LW-1:0] left_next, right_next;
  logic [DW-1:0] row_diff;
  logic [CW:0]   col_inc, row_inc;
  logic          col_wrap, row_wrap;
  logic          texel_last;

  assign left_next  = left_light_q + left_vstep_q;
  assign right_next = right_light_q + right_vstep_q;
  assign row_diff   = {right_next[LW-1], right_next} - {left_next[LW-1], left_next};
  assign col_inc    = {1'b0, col_count_q} + (CW+1)'(1);
  assign row_inc    = {1'b0, row_count_q} + (CW+1)'(1);
  assign col_wrap   = col_inc >= side;
  assign row_wrap   = row_inc >= side;
  assign texel_last = ({1'b0, col_count_q} == side_m1) && ({1'b0, row_count_q} == side_m1);

  // Corner differences of a block start; the corners are unsigned 14-bit values.
  logic [DW-1:0] lv_diff, rv_diff, h_diff;

  assign lv_diff = DW'(in_data_i.bottom_left)  - DW'(in_data_i.top_left);
  assign rv_diff = DW'(in_data_i.bottom_right) - DW'(in_data_i.top_right);
  assign h_diff  = DW'(in_data_i.top_right)    - DW'(in_data_i.top_left);

  always_comb begin
    left_light_d  = left_light_q;
    right_light_d = right_light_q;
    left_vstep_d  = left_vstep_q;
    right_vstep_d = right_vstep_q;
    row_light_d   = row_light_q;
    row_step_d    = row_step_q;
    col_count_d   = col_count_q;
    row_count_d   = row_count_q;
    if (in_acc && is_block) begin
      left_light_d  = LW'(in_data_i.top_left);
      right_light_d = LW'(in_data_i.top_right);
      left_vstep_d  = step_of(lv_diff, shamt);
      right_vstep_d = step_of(rv_diff, shamt);
      row_light_d   = LW'(in_data_i.top_left);
      row_step_d    = step_of(h_diff, shamt);
      col_count_d   = '0;
      row_count_d   = '0;
    end else if (in_acc && is_texel) begin
      if (col_wrap) begin
        // End of a row: restart at the stepped left edge with a fresh horizontal step.
        col_count_d   = '0;
        row_count_d   = row_wrap ? '0 : row_inc[CW-1:0];
        left_light_d  = left_next;
        right_light_d = right_next;
        row_light_d   = left_next;
        row_step_d    = step_of(row_diff, shamt);
      end else begin
        col_count_d = col_inc[CW-1:0];
        row_light_d = row_light_q + row_step_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_light_q  <= '0;
      right_light_q <= '0;
      left_vstep_q  <= '0;
      right_vstep_q <= '0;
      row_light_q   <= '0;
      row_step_q    <= '0;
      col_count_q   <= '0;
      row_count_q   <= '0;
    end else begin
      left_light_q  <= left_light_d;
      right_light_q <= right_light_d;
      left_vstep_q  <= left_vstep_d;
      right_vstep_q <= right_vstep_d;
      row_light_q   <= row_light_d;
      row_step_q    <= row_step_d;
      col_count_q   <= col_count_d;
      row_count_q   <= row_count_d;
    end
  end

  // Colormap access. A lookup address is the light's integer part joined with the texel
  // index; an address beyond the memory reads as zero, and a load beyond it is dropped.
  // A load writes at its accepting edge, so a lookup one beat later already sees it.
  logic [XW-1:0]           rd_full, wr_full;
  logic                    rd_in_range, wr_in_range;
  logic                    ram_we, ram_re;
  logic [AW-1:0]           ram_addr;
  logic [lts_pkg::BYTE_W-1:0] ram_rdata;

  assign rd_full     = XW'({row_light_q[LW-1:8], in_data_i.texel});
  assign wr_full     = XW'(in_data_i.table_index);
  assign rd_in_range = rd_full < XW'(SHADE_TABLE_DEPTH);
  assign wr_in_range = wr_full < XW'(SHADE_TABLE_DEPTH);
  assign ram_we      = in_acc && is_load && wr_in_range;
  assign ram_re      = in_acc && is_texel;
  assign ram_addr    = is_load ? wr_full[AW-1:0] : rd_full[AW-1:0];

  lts_ram #(
    .WIDTH (lts_pkg::BYTE_W),
    .DEPTH (SHADE_TABLE_DEPTH)
  ) u_shade_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (in_data_i.table_value),
    .rdata_o (ram_rdata)
  );

  // Stage one side information travels next to the memory read.
  logic [lts_pkg::POS_W-1:0] s1_pos_x_q, s1_pos_y_q;
  logic                      s1_last_q, s1_oob_q;

  always_ff @(posedge clk_i) begin
    if (ram_re) begin
      s1_pos_x_q <= lts_pkg::POS_W'(col_count_q);
      s1_pos_y_q <= lts_pkg::POS_W'(row_count_q);
      s1_last_q  <= texel_last;
      s1_oob_q   <= !rd_in_range;
    end
  end

  assign s1_valid_d  = ram_re ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);
  assign out_valid_d = s1_adv ? s1_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  lts_pkg::out_beat_t out_q;

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s1_adv) begin
      out_q.pixel <= s1_oob_q ? '0 : ram_rdata;
      out_q.pos_x <= s1_pos_x_q;
      out_q.pos_y <= s1_pos_y_q;
      out_q.last  <= s1_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A held stage-one result keeps its memory data until it moves on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(ram_rdata))
    else $error("stage one data changed while held");

  // Every accepted texel occupies stage one in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && is_texel |=> s1_valid_q)
    else $error("texel beat lost before stage one");

  // Beats that produce no result leave stage one empty once it has drained.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !is_texel && s1_adv |=> !s1_valid_q)
    else $error("result invented for a non-texel beat");

  // The last texel of a block sits on the diagonal corner.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.last |-> out_data_o.pos_x == out_data_o.pos_y)
    else $error("last flag off the final corner");

endmodule
